// File: hdl/fla_pkg.sv
package fla_pkg;

  localparam int CELL_W     = 10;
  localparam int LINK_W     = 11;
  localparam int LINK_DEPTH = 1024;
  localparam int COUNT_W    = 11;
  localparam int BLOCKS_W   = 5;
  localparam int ADDR_W     = 20;
  localparam int BCELLS_W   = 7;
  localparam int EBYTES_W   = 11;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int DEF_MAX_BLOCKS      = 16;
  localparam int DEF_MAX_BLOCK_CELLS = 64;

  localparam logic [LINK_W-1:0]  NULL_LINK = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [BCELLS_W-1:0] BLOCK_CELLS_RST = BCELLS_W'(5);
  localparam logic [EBYTES_W-1:0] ELEM_BYTES_RST  = EBYTES_W'(8);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NO_LIVE   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_CELLS = 2'd0,
    CFG_ELEM_BYTES  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [BCELLS_W-1:0] block_cells;
    logic [EBYTES_W-1:0] elem_bytes;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

endpackage

// File: hdl/fla_if.sv
interface fla_req_if import fla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CELL_W-1:0] cell_index;

  modport source(output valid, func, cell_index, input ready);
  modport sink(input valid, func, cell_index, output ready);
endinterface

interface fla_rsp_if import fla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CELL_W-1:0]   granted_cell;
  logic [ADDR_W-1:0]   byte_address;
  logic                grew;
  logic [COUNT_W-1:0]  live_count;
  logic [COUNT_W-1:0]  free_count;
  logic [BLOCKS_W-1:0] blocks_used;

  modport source(output valid, status, granted_cell, byte_address, grew, live_count,
                 free_count, blocks_used, input ready);
  modport sink(input valid, status, granted_cell, byte_address, grew, live_count,
               free_count, blocks_used, output ready);
endinterface

interface fla_cfg_if import fla_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/fla_ram.sv
module fla_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/fla_cfg.sv
module fla_cfg import fla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fla_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  logic [BCELLS_W-1:0] block_cells_q, block_cells_d;
  logic [EBYTES_W-1:0] elem_bytes_q, elem_bytes_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    block_cells_d = block_cells_q;
    elem_bytes_d  = elem_bytes_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BLOCK_CELLS: block_cells_d = cfg_i.data[BCELLS_W-1:0];
        CFG_ELEM_BYTES:  elem_bytes_d  = cfg_i.data[EBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_cells_q <= BLOCK_CELLS_RST;
      elem_bytes_q  <= ELEM_BYTES_RST;
    end else begin
      block_cells_q <= block_cells_d;
      elem_bytes_q  <= elem_bytes_d;
    end
  end

  assign cfg_o.block_cells = block_cells_q;
  assign cfg_o.elem_bytes  = elem_bytes_q;

endmodule

// File: hdl/fla_core.sv
module fla_core import fla_pkg::*; #(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int MAX_BLOCK_CELLS = DEF_MAX_BLOCK_CELLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  fla_req_if.sink           req_i,
  fla_rsp_if.source         rsp_o,
  output link_wr_t          link_wr_o,
  output logic [CELL_W-1:0] link_raddr_o,
  input  logic [LINK_W-1:0] link_rdata_i
);

  localparam int BlkW = $clog2(MAX_BLOCKS + 1);
  localparam int IdxW = $clog2(MAX_BLOCK_CELLS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_GROW = 3'b100
  } state_e;

  state_e              state_q, state_d;
  func_e               func_q;
  logic [CELL_W-1:0]   cell_q;
  logic [LINK_W-1:0]   head_q, head_d;
  logic [COUNT_W-1:0]  live_q, live_d;
  logic [COUNT_W-1:0]  free_q, free_d;
  logic [BlkW-1:0]     blocks_q, blocks_d;
  logic [IdxW-1:0]     idx_q, idx_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [CELL_W-1:0]   out_cell_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic                out_grew_q;
  logic [COUNT_W-1:0]  out_live_q;
  logic [COUNT_W-1:0]  out_free_q;
  logic [BLOCKS_W-1:0] out_blocks_q;

  logic                accept;
  logic                out_free;
  logic                commit;
  status_e             res_status;
  logic [CELL_W-1:0]   res_cell;
  logic                res_grew;
  logic [20:0]         res_prod;
  logic [IdxW-1:0]     n_eff;
  logic [31:0]         base_full;
  logic [CELL_W-1:0]   base;
  logic [CELL_W-1:0]   grow_cell;
  logic                grow_last;
  logic [COUNT_W:0]    free_sum;
  logic [COUNT_W-1:0]  free_grown;
  logic                head_null;
  logic                can_grow;
  link_wr_t            link_wr;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // The link entry behind the current head is always being read, so it is ready
  // in the cycle after an item is taken.
  assign link_raddr_o = head_q[CELL_W-1:0];

  // Block size is clamped to at least one cell and at most a full block slot.
  always_comb begin
    if (cfg_i.block_cells == '0) begin
      n_eff = IdxW'(1);
    end else if (32'(cfg_i.block_cells) > 32'(MAX_BLOCK_CELLS)) begin
      n_eff = IdxW'(MAX_BLOCK_CELLS);
    end else begin
      n_eff = IdxW'(cfg_i.block_cells);
    end
  end

  assign base_full = 32'(blocks_q) * 32'(MAX_BLOCK_CELLS);
  assign base      = base_full[CELL_W-1:0];
  assign grow_cell = base + CELL_W'(idx_q);
  assign grow_last = (idx_q == n_eff - IdxW'(1));
  assign head_null = (head_q == NULL_LINK);
  assign can_grow  = (blocks_q < BlkW'(MAX_BLOCKS));
  assign free_sum  = (COUNT_W + 1)'(free_q) + (COUNT_W + 1)'(n_eff);
  assign free_grown = free_sum[COUNT_W] ? COUNT_MAX : free_sum[COUNT_W-1:0];

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    live_d     = live_q;
    free_d     = free_q;
    blocks_d   = blocks_q;
    idx_d      = idx_q;
    commit     = 1'b0;
    res_status = ST_OK;
    res_cell   = '0;
    res_grew   = 1'b0;
    link_wr.we   = 1'b0;
    link_wr.addr = cell_q;
    link_wr.data = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_q)
          FUNC_ALLOC: begin
            if (head_null && can_grow) begin
              state_d = S_GROW;
              idx_d   = '0;
            end else if (head_null) begin
              commit     = out_free;
              res_status = ST_EXHAUSTED;
            end else begin
              commit   = out_free;
              res_cell = head_q[CELL_W-1:0];
              head_d   = link_rdata_i;
              free_d   = (free_q == '0) ? free_q : free_q - COUNT_W'(1);
              live_d   = (live_q == COUNT_MAX) ? live_q : live_q + COUNT_W'(1);
            end
          end
          FUNC_FREE: begin
            if (live_q == '0) begin
              commit     = out_free;
              res_status = ST_NO_LIVE;
            end else begin
              commit     = out_free;
              link_wr.we = out_free;
              head_d     = {1'b0, cell_q};
              free_d     = (free_q == COUNT_MAX) ? free_q : free_q + COUNT_W'(1);
              live_d     = live_q - COUNT_W'(1);
            end
          end
          default: begin
            commit = out_free;
          end
        endcase
      end
      S_GROW: begin
        // One link write per cycle, ascending; the last cell ends the list.
        link_wr.we   = 1'b1;
        link_wr.addr = grow_cell;
        link_wr.data = grow_last ? NULL_LINK : {1'b0, grow_cell + CELL_W'(1)};
        if (!grow_last) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          // The first cell of the block is popped right away.
          commit   = out_free;
          res_grew = 1'b1;
          res_cell = base;
          head_d   = (n_eff == IdxW'(1)) ? NULL_LINK : {1'b0, base + CELL_W'(1)};
          free_d   = free_grown - COUNT_W'(1);
          live_d   = (live_q == COUNT_MAX) ? live_q : live_q + COUNT_W'(1);
          blocks_d = blocks_q + BlkW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (commit) begin
      state_d = S_IDLE;
    end else begin
      head_d   = head_q;
      live_d   = live_q;
      free_d   = free_q;
      blocks_d = blocks_q;
    end
  end

  assign link_wr_o = link_wr;

  assign res_prod = 21'(res_cell) * 21'(cfg_i.elem_bytes);

  assign out_valid_d = commit ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NULL_LINK;
      live_q      <= '0;
      free_q      <= '0;
      blocks_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      live_q      <= live_d;
      free_q      <= free_d;
      blocks_q    <= blocks_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(req_i.func);
      cell_q <= req_i.cell_index;
    end
    if (commit) begin
      out_status_q <= res_status;
      out_cell_q   <= res_cell;
      out_addr_q   <= res_prod[ADDR_W-1:0];
      out_grew_q   <= res_grew;
      out_live_q   <= live_d;
      out_free_q   <= free_d;
      out_blocks_q <= BLOCKS_W'(blocks_d);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.granted_cell = out_cell_q;
  assign rsp_o.byte_address = out_addr_q;
  assign rsp_o.grew         = out_grew_q;
  assign rsp_o.live_count   = out_live_q;
  assign rsp_o.free_count   = out_free_q;
  assign rsp_o.blocks_used  = out_blocks_q;

  // An empty free list always comes with a zero free count. A double free can
  // close the list into a loop, so a zero count does not imply an empty list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NULL_LINK) |-> (free_q == '0))
    else $error("free list head and free count disagree");

  // Every finished item returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result not presented after commit");

  // The pool never grows past its block limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocks_q <= BlkW'(MAX_BLOCKS))
    else $error("block count above limit");

  // A grow only starts from an empty list and never writes past its block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GROW) |-> head_null && (idx_q < n_eff))
    else $error("link write outside the growing block");

endmodule

// File: hdl/free_list_cell_allocator.sv
// An item is taken only when idle; the execute state registers the result for a pop
// from a non-empty list, a free, a rejected item or a query. An allocate that grows
// the pool links the new block in the grow state, one link write per cycle, and
// registers its result with the last write; both states wait for a free output.
// Reset: counts clear, the list head becomes empty; the link memory is not cleared.
module free_list_cell_allocator import fla_pkg::*; #(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int MAX_BLOCK_CELLS = DEF_MAX_BLOCK_CELLS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fla_cfg_if.sink   cfg_i,
  fla_req_if.sink   req_i,
  fla_rsp_if.source rsp_o
);

  cfg_t              cfg;
  link_wr_t          link_wr;
  logic [CELL_W-1:0] link_raddr;
  logic [LINK_W-1:0] link_rdata;

  fla_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fla_ram #(
    .Width (LINK_W),
    .Depth (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_wr.we),
    .waddr_i (link_wr.addr),
    .wdata_i (link_wr.data),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  fla_core #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_BLOCK_CELLS (MAX_BLOCK_CELLS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .link_wr_o    (link_wr),
    .link_raddr_o (link_raddr),
    .link_rdata_i (link_rdata)
  );

endmodule

// File: test/tb_free_list_cell_allocator.sv
`timescale 1ns / 1ps

module tb_free_list_cell_allocator;
  import fla_pkg::*;

  // Function code 3 has no name in the package; the block treats it as a query.
  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [CELL_W-1:0] handle;
  } cell_op_t;

  typedef struct {
    status_e             status;
    logic [CELL_W-1:0]   granted;
    logic [ADDR_W-1:0]   addr;
    logic                grew;
    logic [COUNT_W-1:0]  live;
    logic [COUNT_W-1:0]  free;
    logic [BLOCKS_W-1:0] blocks;
  } pool_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fla_cfg_if cfg_bus();
  fla_req_if req_bus();
  fla_rsp_if rsp_bus();

  free_list_cell_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the pool: link memory, list head, counts and the two registers.
  logic [LINK_W-1:0]   link_mem [LINK_DEPTH];
  logic [LINK_W-1:0]   head_m;
  logic [COUNT_W-1:0]  live_m;
  logic [COUNT_W-1:0]  free_m;
  logic [BLOCKS_W-1:0] blocks_m;
  logic [BCELLS_W-1:0] bcells_m;
  logic [EBYTES_W-1:0] ebytes_m;
  // Cells handed out and not yet returned; the generator frees from this set.
  bit                  live_map [LINK_DEPTH];

  cell_op_t    cell_op_q[$];
  pool_reply_t pool_reply_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_cnt;

  function automatic pool_reply_t step_pool(logic [FUNC_W-1:0] func,
                                            logic [CELL_W-1:0] handle);
    pool_reply_t       r;
    int unsigned       n;
    int unsigned       base;
    int unsigned       prod;
    logic [CELL_W-1:0] g;
    r = '{ST_OK, '0, '0, 1'b0, '0, '0, '0};
    if (func == FUNC_ALLOC) begin
      if (head_m == NULL_LINK && blocks_m < DEF_MAX_BLOCKS) begin
        n = (bcells_m == 0) ? 1 :
            (bcells_m > DEF_MAX_BLOCK_CELLS) ? DEF_MAX_BLOCK_CELLS : bcells_m;
        base = blocks_m * DEF_MAX_BLOCK_CELLS;
        for (int i = 0; i < n; i++) begin
          link_mem[(base + i) % LINK_DEPTH] =
            (i + 1 == n) ? NULL_LINK : LINK_W'((base + i + 1) % LINK_DEPTH);
        end
        head_m   = LINK_W'(base % LINK_DEPTH);
        free_m   = (free_m + n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(free_m + n);
        blocks_m = blocks_m + 1'b1;
        r.grew   = 1'b1;
      end
      if (head_m == NULL_LINK) begin
        r.status = ST_EXHAUSTED;
      end else begin
        g      = head_m[CELL_W-1:0];
        head_m = link_mem[g];
        if (free_m != 0) free_m = free_m - 1'b1;
        if (live_m != COUNT_MAX) live_m = live_m + 1'b1;
        prod        = 32'(g);
        prod        = prod * ebytes_m;
        r.granted   = g;
        r.addr      = ADDR_W'(prod);
        live_map[g] = 1'b1;
      end
    end else if (func == FUNC_FREE) begin
      if (live_m == 0) begin
        r.status = ST_NO_LIVE;
      end else begin
        link_mem[handle] = head_m;
        head_m           = {1'b0, handle};
        if (free_m != COUNT_MAX) free_m = free_m + 1'b1;
        live_m           = live_m - 1'b1;
        live_map[handle] = 1'b0;
      end
    end
    r.live   = live_m;
    r.free   = free_m;
    r.blocks = blocks_m;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_reply();
    pool_reply_t exp;
    if (pool_reply_q.size() == 0) begin
      report_mismatch("reply item arrived with no operation outstanding");
      return;
    end
    exp = pool_reply_q.pop_front();
    if (rsp_bus.status !== exp.status)
      report_mismatch($sformatf("status %0d, expected %0d", rsp_bus.status, exp.status));
    if (rsp_bus.granted_cell !== exp.granted)
      report_mismatch($sformatf("granted_cell %0d, expected %0d",
                                rsp_bus.granted_cell, exp.granted));
    if (rsp_bus.byte_address !== exp.addr)
      report_mismatch($sformatf("byte_address %0d, expected %0d",
                                rsp_bus.byte_address, exp.addr));
    if (rsp_bus.grew !== exp.grew)
      report_mismatch($sformatf("grew %0d, expected %0d", rsp_bus.grew, exp.grew));
    if (rsp_bus.live_count !== exp.live)
      report_mismatch($sformatf("live_count %0d, expected %0d",
                                rsp_bus.live_count, exp.live));
    if (rsp_bus.free_count !== exp.free)
      report_mismatch($sformatf("free_count %0d, expected %0d",
                                rsp_bus.free_count, exp.free));
    if (rsp_bus.blocks_used !== exp.blocks)
      report_mismatch($sformatf("blocks_used %0d, expected %0d",
                                rsp_bus.blocks_used, exp.blocks));
  endtask

  // Request driver: the expectation is formed at the edge where the item is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        pool_reply_q.push_back(step_pool(req_bus.func, req_bus.cell_index));
        void'(cell_op_q.pop_front());
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (cell_op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_bus.valid      <= 1'b1;
          req_bus.func       <= cell_op_q[0].func;
          req_bus.cell_index <= cell_op_q[0].handle;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) check_reply();
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_BLOCK_CELLS) bcells_m = value[BCELLS_W-1:0];
    else ebytes_m = value[EBYTES_W-1:0];
  endtask

  task automatic wait_drained();
    while (cell_op_q.size() != 0 || pool_reply_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic queue_op(logic [FUNC_W-1:0] func, logic [CELL_W-1:0] handle);
    cell_op_t op;
    op.func   = func;
    op.handle = handle;
    cell_op_q.push_back(op);
  endtask

  // Items are made in short batches so that frees can name cells that are live
  // in the mirror once the previous batch has been taken.
  task automatic run_phase(logic [CFG_DATA_W-1:0] bc, logic [CFG_DATA_W-1:0] eb,
                           int n_items, int alloc_pct, int noise_pct);
    int                sent;
    int                batch;
    int                pick;
    int                r;
    cell_op_t          op;
    logic [CELL_W-1:0] live_list[$];
    wait_drained();
    write_reg(CFG_BLOCK_CELLS, bc);
    write_reg(CFG_ELEM_BYTES, eb);
    sent = 0;
    while (sent < n_items) begin
      while (cell_op_q.size() != 0) @(negedge clk_i);
      live_list.delete();
      for (int c = 0; c < LINK_DEPTH; c++) begin
        if (live_map[c]) live_list.push_back(CELL_W'(c));
      end
      batch = $urandom_range(1, 8);
      for (int k = 0; k < batch; k++) begin
        r         = $urandom_range(0, 99);
        op.handle = CELL_W'($urandom_range(0, LINK_DEPTH - 1));
        if (r < noise_pct) begin
          // Any code and any handle: foreign and double frees land here.
          op.func = FUNC_W'($urandom_range(0, 3));
        end else if (r < noise_pct + alloc_pct) begin
          op.func = FUNC_ALLOC;
        end else if (r < noise_pct + alloc_pct + 4) begin
          op.func = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_UNDEF;
        end else if (live_list.size() != 0) begin
          pick      = $urandom_range(0, live_list.size() - 1);
          op.func   = FUNC_FREE;
          op.handle = live_list[pick];
          live_list.delete(pick);
        end else begin
          op.func = (live_m == 0) ? FUNC_FREE : FUNC_ALLOC;
        end
        cell_op_q.push_back(op);
      end
      sent += batch;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.func  = FUNC_QUERY;
    req_bus.cell_index = '0;
    rsp_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_BLOCK_CELLS;
    cfg_bus.data  = '0;
    head_m        = NULL_LINK;
    live_m        = '0;
    free_m        = '0;
    blocks_m      = '0;
    bcells_m      = BLOCK_CELLS_RST;
    ebytes_m      = ELEM_BYTES_RST;
    mismatch_cnt  = 0;
    send_idle_pct = 13;
    recv_idle_pct = 51;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items run with the register reset values.
    queue_op(FUNC_QUERY, '0);
    queue_op(FUNC_UNDEF, '1);
    queue_op(FUNC_FREE, '1);
    queue_op(FUNC_FREE, '0);
    queue_op(FUNC_ALLOC, '1);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_ALLOC, 10'd682);
    queue_op(FUNC_FREE, 10'd1);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_FREE, '1);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_FREE, 10'd0);
    queue_op(FUNC_FREE, 10'd1023);
    queue_op(FUNC_FREE, 10'd682);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_FREE, 10'd341);
    queue_op(FUNC_QUERY, 10'd341);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_ALLOC, '0);
    queue_op(FUNC_ALLOC, '0);

    // Large blocks first, then one-cell blocks drive the pool to exhaustion.
    run_phase(11'd64, 11'd1024, 110, 70, 0);
    run_phase(11'd127, 11'd8, 90, 70, 0);
    run_phase(11'd0, 11'd0, 90, 90, 0);

    wait_drained();
    send_idle_pct = 51;
    recv_idle_pct = 13;
    run_phase(11'd1, 11'd2047, 90, 50, 0);
    run_phase(CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(8, 1024)),
              90, 50, 0);
    run_phase(11'd5, 11'd1000, 90, 45, 0);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 2047)),
              130, 45, 15);
    run_phase(11'd33, 11'd512, 130, 40, 15);

    wait_drained();
    repeat (70) @(posedge clk_i);
    if (mismatch_cnt == 0 && pool_reply_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
hdl/fla_pkg.sv
hdl/fla_if.sv
hdl/fla_ram.sv
hdl/fla_cfg.sv
hdl/fla_core.sv
hdl/free_list_cell_allocator.sv
test/tb_free_list_cell_allocator.sv
